### rtl/core/tile_constraint_propagation_sweep_defines.svh
// assertion macros for the tile constraint propagation sweep
`ifndef TILE_CONSTRAINT_PROPAGATION_SWEEP_DEFINES_SVH
`define TILE_CONSTRAINT_PROPAGATION_SWEEP_DEFINES_SVH

// clocked assertion, muted while in reset
`define TCPS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// clocked assertion checked during reset too
`define TCPS_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/tcps_pkg.sv
// shared types and constants of the tile constraint propagation sweep
package tcps_pkg;
	localparam int MAX_WIDTH    = 32;
	localparam int MAX_HEIGHT   = 32;
	localparam int MAX_PATTERNS = 32;
	localparam int PAT_LIMIT    = (MAX_PATTERNS < 32) ? MAX_PATTERNS : 32;
	localparam int X_W          = $clog2(MAX_WIDTH);
	localparam int Y_W          = $clog2(MAX_HEIGHT);
	localparam int ADDR_W       = X_W + Y_W;
	localparam int NCELLS       = MAX_WIDTH * MAX_HEIGHT;
	localparam int P_W          = $clog2(PAT_LIMIT);
	localparam int MASK_W       = 32;

	typedef enum logic [1:0] {
		CMD_LOAD  = 2'd0,
		CMD_WRITE = 2'd1,
		CMD_SWEEP = 2'd2,
		CMD_READ  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		D_LEFT  = 2'd0,
		D_UP    = 2'd1,
		D_RIGHT = 2'd2,
		D_DOWN  = 2'd3
	} dir_t;

	typedef enum logic [1:0] {
		REG_WIDTH   = 2'd0,
		REG_HEIGHT  = 2'd1,
		REG_PATTERN = 2'd2,
		REG_WRAP    = 2'd3
	} reg_idx_t;

	// one cell entry: possibility mask and sticky mark
	typedef struct packed {
		logic [MASK_W-1:0] mask;
		logic              mark;
	} cell_t;
endpackage

### rtl/core/tcps_cell_ram.sv
// cell store: one write port, one read port, registered read data
module tcps_cell_ram
	import tcps_pkg::*;
(
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  cell_t             wdata,
	input  logic [ADDR_W-1:0] raddr,
	output cell_t             rdata
);
	cell_t mem [NCELLS];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end
endmodule

### rtl/core/tcps_rule_bank.sv
// rule rows per direction and neighbor pattern, with the allowed-pattern OR
module tcps_rule_bank
	import tcps_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              we,
	input  dir_t              wdir,
	input  logic [P_W-1:0]    widx,
	input  logic [MASK_W-1:0] wdata,
	input  dir_t              rdir,
	input  logic [MASK_W-1:0] nb_mask,
	output logic [MASK_W-1:0] allow
);
	logic [MASK_W-1:0] rows_q [4][PAT_LIMIT];

	// row load, cleared to nothing allowed at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int d = 0; d < 4; d++) begin
				for (int p = 0; p < PAT_LIMIT; p++) begin
					rows_q[d][p] <= '0;
				end
			end
		end else if (we) begin
			rows_q[wdir][widx] <= wdata;
		end
	end

	// or of the rows of every pattern the neighbor may hold
	always_comb begin
		allow = '0;
		for (int p = 0; p < PAT_LIMIT; p++) begin
			if (nb_mask[p]) begin
				allow = allow | rows_q[rdir][p];
			end
		end
	end
endmodule

### rtl/core/tile_constraint_propagation_sweep.sv
// top level of the tile constraint propagation sweep
// A command is taken when start is high and busy is low, and gives exactly one
// result on the output ports for one cycle with done high; the receiver cannot
// stall it. Rule loads and cell writes leave busy low and give their result in
// the cycle after the transfer; a cell read holds busy through the read state
// and gives its result once that state ends. A sweep walks the cells column by
// column through the single cell memory: per cell it fetches the cell, then per
// direction it goes straight on when the neighbor is skipped or is an unmarked
// self neighbor, fetches another cell and checks it only when it is marked,
// or steps through the patterns one by one when a wrapped neighbor is the
// marked cell itself, and at last writes the cell back. After reset a clearing
// pass sets every cell to all patterns possible; busy is high while it runs.
`include "tile_constraint_propagation_sweep_defines.svh"
module tile_constraint_propagation_sweep
	import tcps_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	output logic              done,
	input  logic [1:0]        cmd,
	input  logic [1:0]        dir,
	input  logic [4:0]        pattern_index,
	input  logic [4:0]        cell_x,
	input  logic [4:0]        cell_y,
	input  logic [31:0]       mask,
	input  logic              mark,
	output logic [31:0]       cell_mask_out,
	output logic              cell_mark_out,
	output logic              sweep_changed,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [5:0]        cfg_wdata
);
	typedef enum logic [10:0] {
		S_IDLE   = 11'b00000000001,
		S_CLEAR  = 11'b00000000010,
		S_READ   = 11'b00000000100,
		S_OWN    = 11'b00000001000,
		S_OWN_LD = 11'b00000010000,
		S_DIR    = 11'b00000100000,
		S_NB     = 11'b00001000000,
		S_ALLOW  = 11'b00010000000,
		S_APPLY  = 11'b00100000000,
		S_SELF   = 11'b01000000000,
		S_WB     = 11'b10000000000
	} state_t;

	state_t            state_q;
	logic [5:0]        grid_width_q, grid_height_q, pattern_count_q;
	logic              wrap_q;
	logic [ADDR_W-1:0] clr_q;
	logic [X_W-1:0]    x_q;
	logic [Y_W-1:0]    y_q;
	dir_t              dir_q;
	logic [P_W-1:0]    t_q;
	cell_t             own_q, nb_q;
	logic [MASK_W-1:0] allow_q;
	logic              changed_q;
	cmd_t              cmd_q;
	logic              done_q;
	logic [MASK_W-1:0] mask_out_q;
	logic              mark_out_q, changed_out_q;

	logic [5:0]        w_c, h_c, np_c;
	logic [X_W-1:0]    wm1;
	logic [Y_W-1:0]    hm1;
	logic [MASK_W-1:0] used;
	logic              accept, size_zero;
	logic              skip, is_self;
	logic [X_W-1:0]    nx;
	logic [Y_W-1:0]    ny;
	logic [MASK_W-1:0] kill, allow, bank_mask;
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr, ram_raddr;
	cell_t             ram_wdata, ram_rdata;

	// sizes saturated at the storage limits
	assign w_c  = (grid_width_q > 6'(MAX_WIDTH)) ? 6'(MAX_WIDTH) : grid_width_q;
	assign h_c  = (grid_height_q > 6'(MAX_HEIGHT)) ? 6'(MAX_HEIGHT) : grid_height_q;
	assign np_c = (pattern_count_q > 6'(PAT_LIMIT)) ? 6'(PAT_LIMIT) : pattern_count_q;
	assign wm1  = X_W'(w_c - 6'd1);
	assign hm1  = Y_W'(h_c - 6'd1);
	assign used = MASK_W'((33'(1) << np_c) - 33'(1));
	assign size_zero = (w_c == 6'd0) || (h_c == 6'd0) || (np_c == 6'd0);
	assign accept = start && !busy;
	assign busy = (state_q != S_IDLE);

	// neighbor of the current cell in the current direction
	always_comb begin
		nx = x_q;
		ny = y_q;
		skip = 1'b0;
		unique case (dir_q)
			D_LEFT: begin
				if (x_q == '0) begin
					skip = !wrap_q;
					nx = wm1;
				end else begin
					nx = x_q - X_W'(1);
				end
			end
			D_UP: begin
				if (y_q == hm1) begin
					skip = !wrap_q;
					ny = '0;
				end else begin
					ny = y_q + Y_W'(1);
				end
			end
			D_RIGHT: begin
				if (x_q == wm1) begin
					skip = !wrap_q;
					nx = '0;
				end else begin
					nx = x_q + X_W'(1);
				end
			end
			D_DOWN: begin
				if (y_q == '0) begin
					skip = !wrap_q;
					ny = hm1;
				end else begin
					ny = y_q - Y_W'(1);
				end
			end
			default: begin
				skip = 1'b1;
			end
		endcase
	end
	assign is_self = (nx == x_q) && (ny == y_q);

	// rule bank sees the neighbor mask, or the own mask for a self neighbor
	assign bank_mask = ((state_q == S_SELF) ? own_q.mask : nb_q.mask) & used;
	assign kill = own_q.mask & ~allow_q & used;

	tcps_rule_bank u_rules (
		.clk     (clk),
		.arst_n  (arst_n),
		.we      (accept && (cmd_t'(cmd) == CMD_LOAD)),
		.wdir    (dir_t'(dir)),
		.widx    (P_W'(pattern_index)),
		.wdata   (mask),
		.rdir    (dir_q),
		.nb_mask (bank_mask),
		.allow   (allow)
	);

	// cell memory port muxing: clearing pass, cell write, sweep write-back
	always_comb begin
		ram_we = 1'b0;
		ram_waddr = {X_W'(cell_x), Y_W'(cell_y)};
		ram_wdata = '{mask: mask, mark: mark};
		ram_raddr = {X_W'(cell_x), Y_W'(cell_y)};
		if (state_q == S_CLEAR) begin
			ram_we = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = '{mask: '1, mark: 1'b0};
		end else if (state_q == S_WB) begin
			ram_we = 1'b1;
			ram_waddr = {x_q, y_q};
			ram_wdata = own_q;
		end else if (accept && (cmd_t'(cmd) == CMD_WRITE)) begin
			ram_we = 1'b1;
		end
		if (state_q == S_OWN) begin
			ram_raddr = {x_q, y_q};
		end else if (state_q == S_DIR) begin
			ram_raddr = {nx, ny};
		end
	end

	tcps_cell_ram u_cells (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q <= 6'd32;
			grid_height_q <= 6'd32;
			pattern_count_q <= 6'd32;
			wrap_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_WIDTH:   grid_width_q <= cfg_wdata;
				REG_HEIGHT:  grid_height_q <= cfg_wdata;
				REG_PATTERN: pattern_count_q <= cfg_wdata;
				REG_WRAP:    wrap_q <= cfg_wdata[0];
				default:     wrap_q <= wrap_q;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			done_q <= 1'b0;
			cmd_q <= CMD_LOAD;
			x_q <= '0;
			y_q <= '0;
			dir_q <= D_LEFT;
			t_q <= '0;
			changed_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + ADDR_W'(1);
					if (clr_q == ADDR_W'(NCELLS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						cmd_q <= cmd_t'(cmd);
						x_q <= '0;
						y_q <= '0;
						changed_q <= 1'b0;
						case (cmd_t'(cmd))
							CMD_READ: state_q <= S_READ;
							CMD_SWEEP: begin
								if (size_zero) begin
									done_q <= 1'b1;
								end else begin
									state_q <= S_OWN;
								end
							end
							default: done_q <= 1'b1;
						endcase
					end
				end
				S_READ: begin
					done_q <= 1'b1;
					state_q <= S_IDLE;
				end
				S_OWN: begin
					state_q <= S_OWN_LD;
				end
				S_OWN_LD: begin
					dir_q <= D_LEFT;
					state_q <= S_DIR;
				end
				S_DIR: begin
					t_q <= '0;
					if (skip || (is_self && !own_q.mark)) begin
						state_q <= (dir_q == D_DOWN) ? S_WB : S_DIR;
						dir_q <= dir_t'(dir_q + 2'd1);
					end else if (is_self) begin
						state_q <= S_SELF;
					end else begin
						state_q <= S_NB;
					end
				end
				S_NB: begin
					state_q <= S_ALLOW;
				end
				S_ALLOW: begin
					if (nb_q.mark) begin
						state_q <= S_APPLY;
					end else begin
						state_q <= (dir_q == D_DOWN) ? S_WB : S_DIR;
						dir_q <= dir_t'(dir_q + 2'd1);
					end
				end
				S_APPLY: begin
					if (kill != '0) begin
						changed_q <= 1'b1;
					end
					state_q <= (dir_q == D_DOWN) ? S_WB : S_DIR;
					dir_q <= dir_t'(dir_q + 2'd1);
				end
				S_SELF: begin
					if (own_q.mask[t_q] && !allow[t_q]) begin
						changed_q <= 1'b1;
					end
					t_q <= t_q + P_W'(1);
					if ({1'b0, t_q} == (np_c - 6'd1)) begin
						state_q <= (dir_q == D_DOWN) ? S_WB : S_DIR;
						dir_q <= dir_t'(dir_q + 2'd1);
					end
				end
				S_WB: begin
					if (y_q == hm1) begin
						y_q <= '0;
						x_q <= x_q + X_W'(1);
						if (x_q == wm1) begin
							done_q <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							state_q <= S_OWN;
						end
					end else begin
						y_q <= y_q + Y_W'(1);
						state_q <= S_OWN;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// working cell, neighbor and allowed mask
	always_ff @(posedge clk) begin
		if (state_q == S_OWN_LD) begin
			own_q <= ram_rdata;
		end else if (state_q == S_APPLY && kill != '0) begin
			own_q.mask <= own_q.mask & ~kill;
			own_q.mark <= 1'b1;
		end else if (state_q == S_SELF && own_q.mask[t_q] && !allow[t_q]) begin
			own_q.mask[t_q] <= 1'b0;
			own_q.mark <= 1'b1;
		end
		if (state_q == S_NB) begin
			nb_q <= ram_rdata;
		end
		if (state_q == S_ALLOW) begin
			allow_q <= allow;
		end
	end

	// result registers
	always_ff @(posedge clk) begin
		if (state_q == S_READ) begin
			mask_out_q <= ram_rdata.mask;
			mark_out_q <= ram_rdata.mark;
			changed_out_q <= 1'b0;
		end else if (state_q == S_WB) begin
			mask_out_q <= '0;
			mark_out_q <= 1'b0;
			changed_out_q <= changed_q;
		end else if (state_q == S_IDLE) begin
			mask_out_q <= '0;
			mark_out_q <= 1'b0;
			changed_out_q <= 1'b0;
		end
	end

	assign done = done_q;
	assign cell_mask_out = mask_out_q;
	assign cell_mark_out = mark_out_q;
	assign sweep_changed = changed_out_q;

	`TCPS_ASSERT(a_changed_only_sweep, (done && cmd_q != CMD_SWEEP) |-> !sweep_changed, "change flag on a non-sweep transfer")
	`TCPS_ASSERT(a_cell_only_read, (done && cmd_q != CMD_READ) |-> (cell_mask_out == '0 && !cell_mark_out), "cell data on a non-read transfer")
	`TCPS_ASSERT(a_sweep_progress, (accept && cmd_t'(cmd) == CMD_SWEEP) |=> (busy || done), "sweep neither running nor finished")
	`TCPS_ASSERT_ALWAYS(a_no_done_clearing, (state_q == S_CLEAR) |-> !done, "transfer during clearing pass")
endmodule
